// ----- hw/rtl/planar_kinematics_with_friction_top_assert.svh -----
// Assertion macros for the planar kinematics pipeline control (pkf_ctrl).
`ifndef PLANAR_KINEMATICS_WITH_FRICTION_TOP_ASSERT_SVH
`define PLANAR_KINEMATICS_WITH_FRICTION_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PKF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pkf assertion failed");

// next-cycle implication, checked out of reset
`define PKF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pkf assertion failed");

`endif

// ----- hw/rtl/pkf_pkg.sv -----
// Shared types, constants and saturation helper for the planar kinematics block.
package pkf_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned DT_W      = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [DT_W-1:0]   TIME_STEP_RST   = 16'd1092;
	localparam logic [DATA_W-1:0] FRIC_ACCEL_RST  = 32'd0;
	localparam logic [DATA_W-1:0] DT_SQ_RST       =
		32'(int'(TIME_STEP_RST) * int'(TIME_STEP_RST));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP  = 1'b0,
		REG_FRIC_ACCEL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_ld_t;

	typedef struct packed {
		logic              clip;
		logic [DATA_W-1:0] val;
	} sat_t;

	// clip a 40-bit two's complement value to signed 32 bits
	function automatic sat_t sat32(input logic [39:0] x);
		sat_t r;
		r.clip = !((&x[39:31]) || !(|x[39:31]));
		if (!r.clip) begin
			r.val = x[31:0];
		end else if (x[39]) begin
			r.val = 32'h8000_0000;
		end else begin
			r.val = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/planar_kinematics_with_friction_top.sv -----
// Planar kinematic step, Coulomb friction: five stages, one object per unstalled cycle.
//
// Each beat carries one object's Q16.16 position, velocity and acceleration for x and y.
// The block takes one beat every clock cycle while in_ready is high; its five register
// stages are friction adjust, the a*dt and a*dt^2 multipliers, velocity rounding and
// clamp, the v*dt multiplier, and the position sum. Stalls on the output back up
// through the stages only as far as they are full, so the input keeps taking beats
// while bubbles remain. Both axes run side by side in their own datapaths.
// Write time_step (index 0) and friction_accel (index 1) only while the block is empty.
module planar_kinematics_with_friction_top
	import pkf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [DATA_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 friction_on,
	input  logic [DATA_W-1:0]    pos_x,
	input  logic [DATA_W-1:0]    pos_y,
	input  logic [DATA_W-1:0]    vel_x,
	input  logic [DATA_W-1:0]    vel_y,
	input  logic [DATA_W-1:0]    acc_x,
	input  logic [DATA_W-1:0]    acc_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    new_pos_x,
	output logic [DATA_W-1:0]    new_pos_y,
	output logic [DATA_W-1:0]    new_vel_x,
	output logic [DATA_W-1:0]    new_vel_y,
	output logic                 saturated
);

	logic [DT_W-1:0]   time_step_q;
	logic [DATA_W-1:0] dt_sq_q;
	logic [DATA_W-1:0] fric_accel_q;
	pipe_ld_t          ld;
	logic              sat_x, sat_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TIME_STEP_RST;
			dt_sq_q      <= DT_SQ_RST;
			fric_accel_q <= FRIC_ACCEL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_TIME_STEP: begin
					time_step_q <= cfg_wdata[DT_W-1:0];
					dt_sq_q     <= {16'b0, cfg_wdata[DT_W-1:0]} * {16'b0, cfg_wdata[DT_W-1:0]};
				end
				REG_FRIC_ACCEL: begin
					fric_accel_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	pkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ld        (ld)
	);

	pkf_axis u_axis_x (
		.clk        (clk),
		.ld         (ld),
		.fric_on    (friction_on),
		.dt         (time_step_q),
		.dt_sq      (dt_sq_q),
		.fric_accel (fric_accel_q),
		.pos        (pos_x),
		.vel        (vel_x),
		.acc        (acc_x),
		.new_pos    (new_pos_x),
		.new_vel    (new_vel_x),
		.sat        (sat_x)
	);

	pkf_axis u_axis_y (
		.clk        (clk),
		.ld         (ld),
		.fric_on    (friction_on),
		.dt         (time_step_q),
		.dt_sq      (dt_sq_q),
		.fric_accel (fric_accel_q),
		.pos        (pos_y),
		.vel        (vel_y),
		.acc        (acc_y),
		.new_pos    (new_pos_y),
		.new_vel    (new_vel_y),
		.sat        (sat_y)
	);

	assign saturated = sat_x || sat_y;

endmodule

// ----- hw/rtl/pkf_ctrl.sv -----
// Valid/ready control of the five-stage pipeline.
module pkf_ctrl
	import pkf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pipe_ld_t ld
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic [4:0] vld_vec;

	assign rdy5 = !valid_s5 || out_ready;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign ld.s1 = rdy1 && in_valid;
	assign ld.s2 = rdy2 && valid_s1;
	assign ld.s3 = rdy3 && valid_s2;
	assign ld.s4 = rdy4 && valid_s3;
	assign ld.s5 = rdy5 && valid_s4;

	assign in_ready  = rdy1;
	assign out_valid = valid_s5;
	assign vld_vec   = {valid_s1, valid_s2, valid_s3, valid_s4, valid_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

`include "planar_kinematics_with_friction_top_assert.svh"

	`PKF_ASSERT_NOW(a_empty_head_ready, !valid_s1, in_ready)
	`PKF_ASSERT_NOW(a_tail_load_free, ld.s5, !valid_s5 || out_ready)
	`PKF_ASSERT_NEXT(a_fill_count,
		in_valid && in_ready && !(out_valid && out_ready),
		$countones(vld_vec) == $past($countones(vld_vec)) + 1)

endmodule

// ----- hw/rtl/pkf_axis.sv -----
// One axis of the kinematic update: friction adjust, products, velocity, position.
module pkf_axis
	import pkf_pkg::*;
(
	input  logic              clk,
	input  pipe_ld_t          ld,
	input  logic              fric_on,
	input  logic [DT_W-1:0]   dt,
	input  logic [DATA_W-1:0] dt_sq,
	input  logic [DATA_W-1:0] fric_accel,
	input  logic [DATA_W-1:0] pos,
	input  logic [DATA_W-1:0] vel,
	input  logic [DATA_W-1:0] acc,
	output logic [DATA_W-1:0] new_pos,
	output logic [DATA_W-1:0] new_vel,
	output logic              sat
);

	// stage 1: adjusted acceleration
	logic        apply;
	logic [32:0] a_sum;
	logic        a_ovf;

	logic [DATA_W-1:0] p_s1, v_s1;
	logic signed [DATA_W-1:0] a_s1;
	logic        apply_s1, sat_s1;

	assign apply = fric_on && (vel != '0);
	assign a_sum = vel[31] ? ({acc[31], acc} - {fric_accel[31], fric_accel})
	                       : ({acc[31], acc} + {fric_accel[31], fric_accel});
	assign a_ovf = a_sum[32] != a_sum[31];

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			p_s1     <= pos;
			v_s1     <= vel;
			apply_s1 <= apply;
			sat_s1   <= apply && a_ovf;
			if (!apply) begin
				a_s1 <= acc;
			end else if (a_ovf) begin
				a_s1 <= a_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				a_s1 <= a_sum[31:0];
			end
		end
	end

	// stage 2: a*dt and a*dt^2
	logic signed [48:0] adt;
	logic signed [64:0] adt2;
	logic [47:0] adt_s2;
	logic [63:0] adt2_s2;
	logic [DATA_W-1:0] p_s2, v_s2;
	logic apply_s2, sat_s2;

	assign adt  = $signed({{17{a_s1[31]}}, a_s1}) * $signed({33'b0, dt});
	assign adt2 = $signed({{33{a_s1[31]}}, a_s1}) * $signed({33'b0, dt_sq});

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			adt_s2   <= adt[47:0];
			adt2_s2  <= adt2[63:0];
			p_s2     <= p_s1;
			v_s2     <= v_s1;
			apply_s2 <= apply_s1;
			sat_s2   <= sat_s1;
		end
	end

	// stage 3: round, saturate and clamp the velocity
	logic [49:0] vacc;
	sat_t        vsat;
	logic        rev;
	logic [DATA_W-1:0] vn_s3, p_s3;
	logic [46:0] half_s3;
	logic        sat_s3;

	assign vacc = {{2{v_s2[31]}}, v_s2, 16'h0000} + {{2{adt_s2[47]}}, adt_s2}
	            + 50'd32768;
	assign vsat = sat32({{6{vacc[49]}}, vacc[49:16]});
	assign rev  = apply_s2 && ((!v_s2[31] && vsat.val[31])
	           || (v_s2[31] && !vsat.val[31] && vsat.val != '0));

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			vn_s3   <= rev ? '0 : vsat.val;
			p_s3    <= p_s2;
			half_s3 <= adt2_s2[63:17];
			sat_s3  <= sat_s2 || vsat.clip;
		end
	end

	// stage 4: v_new*dt
	logic signed [48:0] vndt;
	logic [47:0] vndt_s4;
	logic [46:0] half_s4;
	logic [DATA_W-1:0] vn_s4, p_s4;
	logic sat_s4;

	assign vndt = $signed({{17{vn_s3[31]}}, vn_s3}) * $signed({33'b0, dt});

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			vndt_s4 <= vndt[47:0];
			half_s4 <= half_s3;
			vn_s4   <= vn_s3;
			p_s4    <= p_s3;
			sat_s4  <= sat_s3;
		end
	end

	// stage 5: position sum, round and saturate
	logic [51:0] pacc;
	sat_t        psat;
	logic [DATA_W-1:0] pos_s5, vel_s5;
	logic sat_s5;

	assign pacc = {{4{p_s4[31]}}, p_s4, 16'h0000} + {{4{vndt_s4[47]}}, vndt_s4}
	            + {{5{half_s4[46]}}, half_s4} + 52'd32768;
	assign psat = sat32({{4{pacc[51]}}, pacc[51:16]});

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			pos_s5 <= psat.val;
			vel_s5 <= vn_s4;
			sat_s5 <= sat_s4 || psat.clip;
		end
	end

	assign new_pos = pos_s5;
	assign new_vel = vel_s5;
	assign sat     = sat_s5;

endmodule
